// ----- rtl/core/acm_pkg.sv -----
// ----------------------------------------------------------------------------
// acm_pkg
// Shared codes, field widths and limits of the multi-pattern matcher.
// ----------------------------------------------------------------------------
package acm_pkg;

	// field widths of the input and result words
	localparam int KIND_W     = 2;
	localparam int SYM_W      = 6;
	localparam int ALPHA_W    = 7;
	localparam int POS_W      = 32;
	localparam int RULE_OUT_W = 10;

	// alphabet size after reset
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 7'd64;

	// most match words one text symbol may produce
	localparam int RESULT_CAP = 32;
	localparam int CNT_W      = 6;

	// input word kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_PAT  = 2'd0,
		KIND_FIN  = 2'd1,
		KIND_TXT  = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// build status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_OVF = 1'b1;

endpackage

// ----- rtl/core/aho_corasick_matcher_top.sv -----
// ----------------------------------------------------------------------------
// aho_corasick_matcher_top
// Multi-pattern matcher: builds a goto trie from pattern words, sets failure
// links on a finish word and reports patterns ending at each text word, up to RESULT_CAP.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_ready  | kind, symbol, pattern_end, text_start
//  out      | out_valid / out_ready| is_status, build_status, match_start,
//           |                      | match_end, match_rule, last
//  cfg      | cfg_we               | cfg_wdata (alphabet size)
//
// Pattern word: a dropped word goes straight to the end step; else the child is
// looked up and checked, and a word that marks a node writes it back as terminal.
// Text word: an invalid symbol is handled in the idle state; else failure hops to
// a transition, the match chain node by node and a flush, plus out_ready waits.
// Finish word: MAX_DEPTH level passes with failure hops, then the status word.
// After reset the goto RAM is cleared one entry a cycle, all 2**(clog2(MAX_NODES)
// + clog2(MAX_SYMBOLS)) entries (65536 at defaults), with in_ready low.
// A result word held in the output register does not block new input words.
// ----------------------------------------------------------------------------
module aho_corasick_matcher_top import acm_pkg::*; #(
	parameter int MAX_NODES   = 1024,
	parameter int MAX_SYMBOLS = 64,
	parameter int MAX_DEPTH   = 32,
	parameter int MAX_RULES   = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [SYM_W-1:0]      symbol,
	input  logic                  pattern_end,
	input  logic                  text_start,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_status,
	output logic                  build_status,
	output logic [POS_W-1:0]      match_start,
	output logic [POS_W-1:0]      match_end,
	output logic [RULE_OUT_W-1:0] match_rule,
	output logic                  last,
	input  logic                  cfg_we,
	input  logic [ALPHA_W-1:0]    cfg_wdata
);

	localparam int NW  = $clog2(MAX_NODES);
	localparam int SW  = $clog2(MAX_SYMBOLS);
	localparam int DW  = $clog2(MAX_DEPTH + 1);
	localparam int RW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int GAW = NW + SW;
	localparam int NEW = NW + SW + NW + 1 + RW + DW;

	logic [ALPHA_W-1:0] alpha_q;

	logic           g_we, g_re;
	logic [GAW-1:0] g_waddr, g_raddr;
	logic [NW-1:0]  g_wdata, g_rdata;
	logic           n_we, n_re;
	logic [NW-1:0]  n_waddr, n_raddr;
	logic [NEW-1:0] n_wdata, n_rdata;

	// alphabet size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// goto table: child index per node and symbol
	acm_ram #(
		.ADDR_W (GAW),
		.DATA_W (NW)
	) u_goto_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (g_waddr),
		.wdata (g_wdata),
		.re    (g_re),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	// node table: parent, symbol, failure link, terminal, rule, depth
	acm_ram #(
		.ADDR_W (NW),
		.DATA_W (NEW)
	) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (n_wdata),
		.re    (n_re),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	acm_engine #(
		.MAX_NODES   (MAX_NODES),
		.MAX_SYMBOLS (MAX_SYMBOLS),
		.MAX_DEPTH   (MAX_DEPTH),
		.MAX_RULES   (MAX_RULES)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.alpha         (alpha_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_kind       (kind),
		.in_sym        (symbol),
		.in_pend       (pattern_end),
		.in_tstart     (text_start),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_is_status (is_status),
		.out_bstat     (build_status),
		.out_start     (match_start),
		.out_end       (match_end),
		.out_rule      (match_rule),
		.out_last      (last),
		.g_we          (g_we),
		.g_waddr       (g_waddr),
		.g_wdata       (g_wdata),
		.g_re          (g_re),
		.g_raddr       (g_raddr),
		.g_rdata       (g_rdata),
		.n_we          (n_we),
		.n_waddr       (n_waddr),
		.n_wdata       (n_wdata),
		.n_re          (n_re),
		.n_raddr       (n_raddr),
		.n_rdata       (n_rdata)
	);

endmodule

// ----- rtl/core/acm_ram.sv -----
// ----------------------------------------------------------------------------
// acm_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module acm_ram #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [0:(1<<ADDR_W)-1];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/acm_engine.sv -----
// ----------------------------------------------------------------------------
// acm_engine
// Sequencer of the matcher: trie insert, level-order failure link pass,
// text walk and match chain, over the goto RAM and the node RAM.
// ----------------------------------------------------------------------------
module acm_engine import acm_pkg::*; #(
	parameter int MAX_NODES   = 1024,
	parameter int MAX_SYMBOLS = 64,
	parameter int MAX_DEPTH   = 32,
	parameter int MAX_RULES   = 1024,
	localparam int NW  = $clog2(MAX_NODES),
	localparam int CW  = $clog2(MAX_NODES + 1),
	localparam int SW  = $clog2(MAX_SYMBOLS),
	localparam int DW  = $clog2(MAX_DEPTH + 1),
	localparam int RW  = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
	localparam int RCW = $clog2(MAX_RULES + 1),
	localparam int GAW = NW + SW,
	localparam int NEW = NW + SW + NW + 1 + RW + DW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [ALPHA_W-1:0]    alpha,
	// input words
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [KIND_W-1:0]     in_kind,
	input  logic [SYM_W-1:0]      in_sym,
	input  logic                  in_pend,
	input  logic                  in_tstart,
	// result words
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  out_is_status,
	output logic                  out_bstat,
	output logic [POS_W-1:0]      out_start,
	output logic [POS_W-1:0]      out_end,
	output logic [RULE_OUT_W-1:0] out_rule,
	output logic                  out_last,
	// goto RAM
	output logic                  g_we,
	output logic [GAW-1:0]        g_waddr,
	output logic [NW-1:0]         g_wdata,
	output logic                  g_re,
	output logic [GAW-1:0]        g_raddr,
	input  logic [NW-1:0]         g_rdata,
	// node RAM
	output logic                  n_we,
	output logic [NW-1:0]         n_waddr,
	output logic [NEW-1:0]        n_wdata,
	output logic                  n_re,
	output logic [NW-1:0]         n_raddr,
	input  logic [NEW-1:0]        n_rdata
);

	typedef struct packed {
		logic [NW-1:0] parent;
		logic [SW-1:0] sym;
		logic [NW-1:0] fail;
		logic          term;
		logic [RW-1:0] rule;
		logic [DW-1:0] depth;
	} node_t;

	typedef enum logic [16:0] {
		S_CLEAR   = 17'h00001,
		S_IDLE    = 17'h00002,
		S_PAT_RD  = 17'h00004,
		S_PAT_CHK = 17'h00008,
		S_PAT_END = 17'h00010,
		S_PAT_TRM = 17'h00020,
		S_STATUS  = 17'h00040,
		S_B_RD    = 17'h00080,
		S_B_CHK   = 17'h00100,
		S_B_PWAIT = 17'h00200,
		S_F_RD    = 17'h00400,
		S_F_CHK   = 17'h00800,
		S_F_NX    = 17'h01000,
		S_C_RD    = 17'h02000,
		S_C_CHK   = 17'h04000,
		S_C_PROC  = 17'h08000,
		S_C_FLUSH = 17'h10000
	} state_t;

	localparam logic MODE_BLD = 1'b0;
	localparam logic MODE_TXT = 1'b1;

	state_t              state_q, state_d;
	logic [GAW-1:0]      clr_q, clr_d;
	logic [NW-1:0]       cursor_q, cursor_d;
	logic                dropped_q, dropped_d;
	logic [RCW-1:0]      rule_cnt_q, rule_cnt_d;
	logic                ovf_q, ovf_d;
	logic [CW-1:0]       node_cnt_q, node_cnt_d;
	logic [NW-1:0]       cur_q, cur_d;
	logic [POS_W-1:0]    pos_q, pos_d;
	logic [SYM_W-1:0]    sym_q, sym_d;
	logic                pend_q, pend_d;
	logic [NW-1:0]       r_q, r_d;
	logic [SW-1:0]       fsym_q, fsym_d;
	logic                mode_q, mode_d;
	node_t               ent_q, ent_d;
	logic [DW-1:0]       bd_q, bd_d;
	logic [NW-1:0]       bn_q, bn_d;
	logic [CNT_W-1:0]    k_q, k_d;
	logic                pnd_v_q, pnd_v_d;
	logic [POS_W-1:0]    pnd_start_q, pnd_start_d;
	logic [RULE_OUT_W-1:0] pnd_rule_q, pnd_rule_d;

	logic                  ov_q, ov_d;
	logic                  o_stat_q, o_stat_d;
	logic                  o_bstat_q, o_bstat_d;
	logic [POS_W-1:0]      o_start_q, o_start_d;
	logic [POS_W-1:0]      o_end_q, o_end_d;
	logic [RULE_OUT_W-1:0] o_rule_q, o_rule_d;
	logic                  o_last_q, o_last_d;

	node_t            n_rd, n_wr;
	logic             out_free;
	logic             in_sym_ok;
	logic             do_adv;
	logic             bn_last;
	logic [DW-1:0]    dep;
	logic [NW-1:0]    base_node;
	logic [POS_W-1:0] base_pos;
	logic [CNT_W-1:0] k_nx;

	assign n_rd     = node_t'(n_rdata);
	assign n_wdata  = NEW'(n_wr);
	assign out_free = !ov_q || out_ready;
	assign in_sym_ok = (ALPHA_W'(in_sym) < alpha) && (32'(in_sym) < MAX_SYMBOLS);
	assign bn_last  = (CW'(bn_q) + CW'(1)) >= node_cnt_q;

	// next state, datapath and memory controls
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		cursor_d    = cursor_q;
		dropped_d   = dropped_q;
		rule_cnt_d  = rule_cnt_q;
		ovf_d       = ovf_q;
		node_cnt_d  = node_cnt_q;
		cur_d       = cur_q;
		pos_d       = pos_q;
		sym_d       = sym_q;
		pend_d      = pend_q;
		r_d         = r_q;
		fsym_d      = fsym_q;
		mode_d      = mode_q;
		ent_d       = ent_q;
		bd_d        = bd_q;
		bn_d        = bn_q;
		k_d         = k_q;
		pnd_v_d     = pnd_v_q;
		pnd_start_d = pnd_start_q;
		pnd_rule_d  = pnd_rule_q;
		ov_d        = ov_q && !out_ready;
		o_stat_d    = o_stat_q;
		o_bstat_d   = o_bstat_q;
		o_start_d   = o_start_q;
		o_end_d     = o_end_q;
		o_rule_d    = o_rule_q;
		o_last_d    = o_last_q;
		g_we        = 1'b0;
		g_waddr     = '0;
		g_wdata     = '0;
		g_re        = 1'b0;
		g_raddr     = '0;
		n_we        = 1'b0;
		n_waddr     = '0;
		n_wr        = '0;
		n_re        = 1'b0;
		n_raddr     = '0;
		in_ready    = 1'b0;
		do_adv      = 1'b0;
		dep         = '0;
		base_node   = '0;
		base_pos    = '0;
		k_nx        = k_q;

		unique case (state_q)
			// zero the goto table, one entry a cycle
			S_CLEAR: begin
				g_we    = 1'b1;
				g_waddr = clr_q;
				clr_d   = clr_q + GAW'(1);
				if (&clr_q) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					sym_d  = in_sym;
					pend_d = in_pend;
					unique case (kind_t'(in_kind))
						KIND_PAT: begin
							if (dropped_q) begin
								state_d = S_PAT_END;
							end else if (!in_sym_ok) begin
								dropped_d = 1'b1;
								ovf_d     = 1'b1;
								state_d   = S_PAT_END;
							end else begin
								state_d = S_PAT_RD;
							end
						end
						KIND_FIN: begin
							bd_d = DW'(1);
							bn_d = NW'(1);
							if (node_cnt_q <= CW'(1)) begin
								state_d = S_STATUS;
							end else begin
								state_d = S_B_RD;
							end
						end
						KIND_TXT: begin
							base_node = in_tstart ? '0 : cur_q;
							base_pos  = in_tstart ? '0 : pos_q;
							if (!in_sym_ok) begin
								cur_d = '0;
								pos_d = base_pos + POS_W'(1);
							end else begin
								pos_d   = base_pos;
								r_d     = base_node;
								fsym_d  = SW'(in_sym);
								mode_d  = MODE_TXT;
								state_d = S_F_RD;
							end
						end
						default: ;
					endcase
				end
			end

			// pattern symbol: look up child and cursor depth
			S_PAT_RD: begin
				g_re    = 1'b1;
				g_raddr = {cursor_q, SW'(sym_q)};
				n_re    = 1'b1;
				n_raddr = cursor_q;
				state_d = S_PAT_CHK;
			end

			S_PAT_CHK: begin
				dep = (cursor_q == '0) ? '0 : n_rd.depth;
				if (g_rdata != '0) begin
					cursor_d = g_rdata;
				end else if (node_cnt_q >= CW'(MAX_NODES) || dep >= DW'(MAX_DEPTH)) begin
					dropped_d = 1'b1;
					ovf_d     = 1'b1;
				end else begin
					g_we        = 1'b1;
					g_waddr     = {cursor_q, SW'(sym_q)};
					g_wdata     = node_cnt_q[NW-1:0];
					n_we        = 1'b1;
					n_waddr     = node_cnt_q[NW-1:0];
					n_wr.parent = cursor_q;
					n_wr.sym    = SW'(sym_q);
					n_wr.depth  = dep + DW'(1);
					node_cnt_d  = node_cnt_q + CW'(1);
					cursor_d    = node_cnt_q[NW-1:0];
				end
				state_d = S_PAT_END;
			end

			// pattern end: mark terminal, take a rule number
			S_PAT_END: begin
				if (!pend_q) begin
					state_d = S_IDLE;
				end else if (dropped_q || rule_cnt_q >= RCW'(MAX_RULES) || cursor_q == '0) begin
					if (!dropped_q && rule_cnt_q >= RCW'(MAX_RULES)) begin
						ovf_d = 1'b1;
					end
					if (rule_cnt_q < RCW'(MAX_RULES)) begin
						rule_cnt_d = rule_cnt_q + RCW'(1);
					end
					cursor_d  = '0;
					dropped_d = 1'b0;
					state_d   = S_IDLE;
				end else begin
					n_re    = 1'b1;
					n_raddr = cursor_q;
					state_d = S_PAT_TRM;
				end
			end

			S_PAT_TRM: begin
				if (!n_rd.term) begin
					n_we      = 1'b1;
					n_waddr   = cursor_q;
					n_wr      = n_rd;
					n_wr.term = 1'b1;
					n_wr.rule = RW'(rule_cnt_q);
				end
				rule_cnt_d = rule_cnt_q + RCW'(1);
				cursor_d   = '0;
				dropped_d  = 1'b0;
				state_d    = S_IDLE;
			end

			S_STATUS: begin
				if (out_free) begin
					ov_d      = 1'b1;
					o_stat_d  = 1'b1;
					o_bstat_d = ovf_q ? STATUS_OVF : STATUS_OK;
					o_start_d = '0;
					o_end_d   = '0;
					o_rule_d  = '0;
					o_last_d  = 1'b1;
					state_d   = S_IDLE;
				end
			end

			// failure pass: nodes of the current level, in index order
			S_B_RD: begin
				n_re    = 1'b1;
				n_raddr = bn_q;
				state_d = S_B_CHK;
			end

			S_B_CHK: begin
				if (n_rd.depth != bd_q) begin
					do_adv = 1'b1;
				end else if (n_rd.parent == '0) begin
					n_we      = 1'b1;
					n_waddr   = bn_q;
					n_wr      = n_rd;
					n_wr.fail = '0;
					do_adv    = 1'b1;
				end else begin
					ent_d   = n_rd;
					n_re    = 1'b1;
					n_raddr = n_rd.parent;
					state_d = S_B_PWAIT;
				end
			end

			S_B_PWAIT: begin
				r_d     = n_rd.fail;
				fsym_d  = ent_q.sym;
				mode_d  = MODE_BLD;
				state_d = S_F_RD;
			end

			// follow failure links until a transition exists
			S_F_RD: begin
				g_re    = 1'b1;
				g_raddr = {r_q, fsym_q};
				state_d = S_F_CHK;
			end

			S_F_CHK: begin
				if (g_rdata != '0 || r_q == '0) begin
					if (mode_q == MODE_BLD) begin
						n_we      = 1'b1;
						n_waddr   = bn_q;
						n_wr      = ent_q;
						n_wr.fail = g_rdata;
						do_adv    = 1'b1;
					end else begin
						cur_d = g_rdata;
						if (g_rdata == '0) begin
							pos_d   = pos_q + POS_W'(1);
							state_d = S_IDLE;
						end else begin
							r_d     = g_rdata;
							k_d     = '0;
							pnd_v_d = 1'b0;
							state_d = S_C_RD;
						end
					end
				end else begin
					n_re    = 1'b1;
					n_raddr = r_q;
					state_d = S_F_NX;
				end
			end

			S_F_NX: begin
				r_d     = n_rd.fail;
				state_d = S_F_RD;
			end

			// match chain: one held result so the final one gets last
			S_C_RD: begin
				n_re    = 1'b1;
				n_raddr = r_q;
				state_d = S_C_CHK;
			end

			S_C_CHK: begin
				ent_d   = n_rd;
				state_d = S_C_PROC;
			end

			S_C_PROC: begin
				if (!(ent_q.term && pnd_v_q && !out_free)) begin
					if (ent_q.term) begin
						if (pnd_v_q) begin
							ov_d      = 1'b1;
							o_stat_d  = 1'b0;
							o_bstat_d = STATUS_OK;
							o_start_d = pnd_start_q;
							o_end_d   = pos_q + POS_W'(1);
							o_rule_d  = pnd_rule_q;
							o_last_d  = 1'b0;
						end
						pnd_v_d     = 1'b1;
						pnd_start_d = pos_q - POS_W'(ent_q.depth) + POS_W'(1);
						pnd_rule_d  = RULE_OUT_W'(ent_q.rule);
						k_nx        = k_q + CNT_W'(1);
					end
					k_d = k_nx;
					if (k_nx == CNT_W'(RESULT_CAP) || ent_q.fail == '0) begin
						state_d = S_C_FLUSH;
					end else begin
						r_d     = ent_q.fail;
						state_d = S_C_RD;
					end
				end
			end

			S_C_FLUSH: begin
				if (!pnd_v_q) begin
					pos_d   = pos_q + POS_W'(1);
					state_d = S_IDLE;
				end else if (out_free) begin
					ov_d      = 1'b1;
					o_stat_d  = 1'b0;
					o_bstat_d = STATUS_OK;
					o_start_d = pnd_start_q;
					o_end_d   = pos_q + POS_W'(1);
					o_rule_d  = pnd_rule_q;
					o_last_d  = 1'b1;
					pnd_v_d   = 1'b0;
					pos_d     = pos_q + POS_W'(1);
					state_d   = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase

		// step to the next node, or the next level, of the failure pass
		if (do_adv) begin
			if (bn_last) begin
				if (bd_q == DW'(MAX_DEPTH)) begin
					state_d = S_STATUS;
				end else begin
					bd_d    = bd_q + DW'(1);
					bn_d    = NW'(1);
					state_d = S_B_RD;
				end
			end else begin
				bn_d    = bn_q + NW'(1);
				state_d = S_B_RD;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cursor_q   <= '0;
			dropped_q  <= 1'b0;
			rule_cnt_q <= '0;
			ovf_q      <= 1'b0;
			node_cnt_q <= CW'(1);
			cur_q      <= '0;
			pos_q      <= '0;
			pnd_v_q    <= 1'b0;
			ov_q       <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			cursor_q   <= cursor_d;
			dropped_q  <= dropped_d;
			rule_cnt_q <= rule_cnt_d;
			ovf_q      <= ovf_d;
			node_cnt_q <= node_cnt_d;
			cur_q      <= cur_d;
			pos_q      <= pos_d;
			pnd_v_q    <= pnd_v_d;
			ov_q       <= ov_d;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		sym_q       <= sym_d;
		pend_q      <= pend_d;
		r_q         <= r_d;
		fsym_q      <= fsym_d;
		mode_q      <= mode_d;
		ent_q       <= ent_d;
		bd_q        <= bd_d;
		bn_q        <= bn_d;
		k_q         <= k_d;
		pnd_start_q <= pnd_start_d;
		pnd_rule_q  <= pnd_rule_d;
		o_stat_q    <= o_stat_d;
		o_bstat_q   <= o_bstat_d;
		o_start_q   <= o_start_d;
		o_end_q     <= o_end_d;
		o_rule_q    <= o_rule_d;
		o_last_q    <= o_last_d;
	end

	assign out_valid     = ov_q;
	assign out_is_status = o_stat_q;
	assign out_bstat     = o_bstat_q;
	assign out_start     = o_start_q;
	assign out_end       = o_end_q;
	assign out_rule      = o_rule_q;
	assign out_last      = o_last_q;

endmodule
